>>> design/bba_pkg.sv
// Package for the block bitmap allocator.
// Holds the map geometry constants, request and status codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } state_t;

endpackage

>>> design/bba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the block free map; no dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/bba_find.sv
// First-free finder: the shared compare unit that locates the lowest set bit of a map word.
// Depends on bba_pkg for the word width.
`timescale 1ns / 1ps

module bba_find
    import bba_pkg::*;
(
    input  logic [WORD_BITS-1:0] free_bits,
    output logic                 found,
    output logic [BIT_IDX_W-1:0] bit_idx
);

    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                found   = 1'b1;
                bit_idx = BIT_IDX_W'(i);
            end
        end
    end

endmodule

>>> design/block_bitmap_allocator_top.sv
// Top level of the block bitmap allocator: sequencer, free map RAM and valid bits.
// Depends on bba_pkg, bba_ram and bba_find.
//
// Usage: a request beat is taken at a rising edge where start is high and busy is low.
// kind selects allocate (first-fit scan from block 0) or free (clear block_number).
// Each request gives exactly one result beat: done is high for one cycle together
// with allocated_block and status. The receiver cannot stall; results must be taken
// in the cycle they appear.
// An allocate reads one 32-bit map word per cycle from the RAM and tests it in the
// shared finder, stopping at the first free block or, with a full result, at the last
// word that holds a block below the block count. A free reads the map word, then
// writes it back. A zero block count or an out-of-range free is answered in the
// cycle after the request without touching the map.
// busy is high while a request is in progress; the next request may be issued in
// the cycle that shows the result.
// cfg_write loads total_blocks from cfg_data; write it only while idle.
// Reset clears every row's valid bit at once, so the whole map reads as free, and
// sets the block count to 4096. No clearing pass is needed.
`timescale 1ns / 1ps

module block_bitmap_allocator_top
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             kind,
    input  logic [BLK_W-1:0] block_number,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data,
    output logic             done,
    output logic [BLK_W-1:0] allocated_block,
    output logic [1:0]       status
);

    state_t                  state_reg, state_next;
    logic [WORD_IDX_W-1:0]   w_reg, w_next;
    logic [BLK_W-1:0]        blk_reg, blk_next;
    logic                    done_reg, done_next;
    logic [BLK_W-1:0]        alloc_reg, alloc_next;
    status_t                 status_reg, status_next;
    logic [CNT_W-1:0]        total_blocks_reg;
    logic [MAP_WORDS-1:0]    valid_reg;
    logic                    vld_q_reg;

    logic                    ram_re;
    logic [WORD_IDX_W-1:0]   ram_raddr;
    logic                    ram_we;
    logic [WORD_IDX_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0]    ram_wdata;
    logic [WORD_BITS-1:0]    ram_rdata;

    logic [CNT_W-1:0]        limit;
    logic [WORD_BITS-1:0]    word_data;
    logic [CNT_W-1:0]        base;
    logic [CNT_W-1:0]        bits_left;
    logic [WORD_BITS-1:0]    lim_mask;
    logic [WORD_BITS-1:0]    free_bits;
    logic                    found;
    logic [BIT_IDX_W-1:0]    bit_idx;
    logic                    last_word;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_find u_find (
        .free_bits (free_bits),
        .found     (found),
        .bit_idx   (bit_idx)
    );

    assign limit     = (total_blocks_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : total_blocks_reg;
    assign word_data = vld_q_reg ? ram_rdata : '0;
    assign base      = {{(CNT_W - WORD_IDX_W - BIT_IDX_W){1'b0}}, w_reg, {BIT_IDX_W{1'b0}}};
    assign bits_left = limit - base;
    assign lim_mask  = (bits_left >= CNT_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
                     : ~({WORD_BITS{1'b1}} << bits_left[BIT_IDX_W-1:0]);
    assign free_bits = ~word_data & lim_mask;
    assign last_word = (bits_left <= CNT_W'(WORD_BITS));

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign allocated_block = alloc_reg;
    assign status          = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            done_reg         <= 1'b0;
            total_blocks_reg <= CNT_W'(MAX_BLOCKS);
            valid_reg        <= '0;
            vld_q_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                total_blocks_reg <= cfg_data;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                vld_q_reg <= valid_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        blk_reg    <= blk_next;
        alloc_reg  <= alloc_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        w_next      = w_reg;
        blk_next    = blk_reg;
        done_next   = 1'b0;
        alloc_next  = alloc_reg;
        status_next = status_reg;
        ram_re      = 1'b0;
        ram_raddr   = w_reg + WORD_IDX_W'(1);
        ram_we      = 1'b0;
        ram_waddr   = w_reg;
        ram_wdata   = word_data | (WORD_BITS'(1) << bit_idx);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_FREE)
                    begin
                        if ({1'b0, block_number} >= limit)
                        begin
                            done_next   = 1'b1;
                            alloc_next  = '0;
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = block_number[BLK_W-1:BIT_IDX_W];
                            blk_next   = block_number;
                            state_next = ST_FREE;
                        end
                    end
                    else if (limit == '0)
                    begin
                        done_next   = 1'b1;
                        alloc_next  = '0;
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        w_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    ram_we      = 1'b1;
                    done_next   = 1'b1;
                    alloc_next  = {w_reg, bit_idx};
                    status_next = STATUS_DONE;
                    state_next  = ST_IDLE;
                end
                else if (last_word)
                begin
                    done_next   = 1'b1;
                    alloc_next  = '0;
                    status_next = STATUS_FULL;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ram_re = 1'b1;
                    w_next = w_reg + WORD_IDX_W'(1);
                end
            end
            ST_FREE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = blk_reg[BLK_W-1:BIT_IDX_W];
                ram_wdata   = word_data & ~(WORD_BITS'(1) << blk_reg[BIT_IDX_W-1:0]);
                done_next   = 1'b1;
                alloc_next  = '0;
                status_next = STATUS_DONE;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A result beat always follows a request taken or a request in progress.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("result beat without a request");

    // A hit during the scan produces a successful result in the next cycle.
    a_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && found) |=> (done && status == STATUS_DONE))
        else $error("scan hit did not complete");

    // The map is only written while a request is in progress.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("map written while idle");

    // A failed request never reports a block number.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_DONE) |-> (allocated_block == '0))
        else $error("failed request carries a block number");
`endif

endmodule
